[rtl/core/assert_macros.svh]
// Assertion shorthands shared by the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising edge, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/bce_pkg.sv]
// Shared constants, types and helpers of the bitmask circle erase core.
package bce_pkg;

   localparam int COORD_W    = 11;   // signed pixel coordinates
   localparam int RAD_IN_W   = 6;    // radius field
   localparam int ALPHA_W    = 8;
   localparam int COUNT_W    = 19;   // pixel counters
   localparam int CFG_W      = 10;   // active size registers
   localparam int CSR_IDX_W  = 1;
   localparam int WORD_BITS  = 64;   // map bits per memory word
   localparam int WORD_BYTES = WORD_BITS / 8;
   localparam int LW         = 6;    // log2 of WORD_BITS

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;
   localparam int DEF_MAX_RADIUS = 63;

   localparam logic [CFG_W-1:0] CFG_DIM_RESET = 10'd512;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_ERASE = 2'd2,
      OP_QUERY = 2'd3
   } bce_op_type;

   // Commands into the circle row walker.
   typedef struct packed {
      logic start;
      logic advance;
   } bce_walk_cmd_type;

   // Status out of the circle row walker.
   typedef struct packed {
      logic settled;    // half width of the current row is final
      logic last_row;   // current row is the bottom row of the circle
   } bce_walk_stat_type;

   function automatic int imax(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

[rtl/core/bce_circle_walk.sv]
// Circle row walker: steps dy from -r to r and tracks the half width of each row.
module bce_circle_walk #(
   parameter int RAD_W = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bce_pkg::bce_walk_cmd_type  walk_cmd,
   input  logic [RAD_W-1:0]           radius,
   output bce_pkg::bce_walk_stat_type walk_stat,
   output logic signed [RAD_W:0]      row_dy,
   output logic [RAD_W-1:0]           half_width
);
   import bce_pkg::*;

   // err = r*r - dy*dy - half*half, kept exact by increments
   localparam int ERR_W = 2 * RAD_W + 3;

   logic                    active_ff, active_in;
   logic signed [RAD_W:0]   dy_ff, dy_in;
   logic [RAD_W-1:0]        half_ff, half_in;
   logic [RAD_W-1:0]        rad_ff, rad_in;
   logic signed [ERR_W-1:0] err_ff, err_in;

   logic signed [ERR_W-1:0] grow_err;
   logic signed [ERR_W-1:0] shrink_err;
   logic signed [ERR_W-1:0] step_err;
   logic                    err_neg;
   logic                    grow_ok;
   logic                    settled;
   logic                    last_row;

   // grow: half+1 costs 2*half+1; shrink: half-1 gives back 2*half-1
   assign grow_err   = err_ff - $signed({{(ERR_W-RAD_W-1){1'b0}}, half_ff, 1'b1});
   assign shrink_err = err_ff + $signed({{(ERR_W-RAD_W-1){1'b0}}, half_ff, 1'b0})
                       - $signed(ERR_W'(1));
   // dy+1 costs 2*dy+1
   assign step_err   = err_ff - $signed({{(ERR_W-RAD_W-2){dy_ff[RAD_W]}}, dy_ff, 1'b1});

   assign err_neg  = err_ff[ERR_W-1];
   assign grow_ok  = !grow_err[ERR_W-1];
   assign settled  = active_ff && !err_neg && !grow_ok;
   assign last_row = (dy_ff == $signed({1'b0, rad_ff}));

   always_comb begin
      active_in = active_ff;
      dy_in     = dy_ff;
      half_in   = half_ff;
      rad_in    = rad_ff;
      err_in    = err_ff;
      priority if (walk_cmd.start) begin
         active_in = 1'b1;
         rad_in    = radius;
         dy_in     = -$signed({1'b0, radius});
         half_in   = '0;
         err_in    = '0;
      end else if (active_ff && err_neg) begin
         half_in = half_ff - RAD_W'(1);
         err_in  = shrink_err;
      end else if (active_ff && grow_ok) begin
         half_in = half_ff + RAD_W'(1);
         err_in  = grow_err;
      end else if (walk_cmd.advance) begin
         if (last_row) begin
            active_in = 1'b0;
         end else begin
            dy_in  = dy_ff + $signed((RAD_W+1)'(1));
            err_in = step_err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      dy_ff   <= dy_in;
      half_ff <= half_in;
      rad_ff  <= rad_in;
      err_ff  <= err_in;
   end

   assign walk_stat.settled  = settled;
   assign walk_stat.last_row = last_row;
   assign row_dy             = dy_ff;
   assign half_width         = half_ff;

endmodule

[rtl/core/bitmask_circle_erase_core.sv]
// Bitmask circle erase core: one-bit solidity map with solid and loaded pixel counters.
//
// The map lives in one synchronous RAM of 64-bit words (MAX_WIDTH*MAX_HEIGHT bits, 4096
// words at the default size); pixel (x,y) is bit y*width+x of the active area. One
// transaction is taken at a time and answers with exactly one result; the result
// register lets the next request in while the previous result waits. Load and hit
// query step through index multiply, word read, read-modify-write and result, or go
// straight to the result when the pixel is outside the map. Clear sweeps every RAM
// word, one per cycle. Erase walks the circle one row at a time: the walker moves the
// row half width one step per cycle until it settles, and a row that touches the map
// then takes a row base multiply and a span word range step and reads the words its
// clipped span covers, one 64-bit word a cycle through the single RAM read port; the
// erase count follows through the span read and popcount registers. After reset the
// same clearing sweep runs before the first request is taken; csr writes are taken
// throughout.
module bitmask_circle_erase_core #(
   parameter int MAX_WIDTH  = bce_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bce_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = bce_pkg::DEF_MAX_RADIUS
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_type,
   input  logic signed [bce_pkg::COORD_W-1:0] req_x_pos,
   input  logic signed [bce_pkg::COORD_W-1:0] req_y_pos,
   input  logic [bce_pkg::RAD_IN_W-1:0]       req_radius,
   input  logic [bce_pkg::ALPHA_W-1:0]        req_pixel_alpha,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic [bce_pkg::COUNT_W-1:0]        rsp_solid_count,
   output logic [bce_pkg::COUNT_W-1:0]        rsp_solid_max,
   // register writes
   input  logic                               csr_we,
   input  logic [bce_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bce_pkg::CFG_W-1:0]          csr_wdata
);
   import bce_pkg::*;

   // ---------------------------------------------------------------- sizes
   localparam int MAP_BITS = MAX_WIDTH * MAX_HEIGHT;
   localparam int IDX_W    = imax($clog2(MAP_BITS), LW + 1);   // bit index
   localparam int WA_W     = IDX_W - LW;                       // word address
   localparam int WORDS    = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WW       = $clog2(MAX_WIDTH + 1);            // active width value
   localparam int HW       = $clog2(MAX_HEIGHT + 1);
   localparam int XW       = imax($clog2(MAX_WIDTH), 1);       // column inside map
   localparam int YW       = imax($clog2(MAX_HEIGHT), 1);      // row inside map
   localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
   localparam int SUM_W    = imax(imax(COORD_W, RAD_W + 1), imax(WW, HW) + 1) + 2;

   // ---------------------------------------------------------------- control FSM
   typedef enum logic [11:0] {
      S_INIT   = 12'b0000_0000_0001,   // clearing sweep after reset
      S_IDLE   = 12'b0000_0000_0010,
      S_CLR    = 12'b0000_0000_0100,   // clearing sweep for a clear request
      S_PT_IDX = 12'b0000_0000_1000,   // pixel index multiply
      S_PT_RD  = 12'b0000_0001_0000,   // word read
      S_PT_WR  = 12'b0000_0010_0000,   // bit update / query
      S_E_ADJ  = 12'b0000_0100_0000,   // wait for row half width, clip span
      S_E_MUL  = 12'b0000_1000_0000,   // row base multiply
      S_E_IDX  = 12'b0001_0000_0000,   // span word range
      S_E_SPAN = 12'b0010_0000_0000,   // one word per cycle
      S_E_NEXT = 12'b0100_0000_0000,   // step to next row
      S_DONE   = 12'b1000_0000_0000    // drain, post result
   } bce_state_type;

   bce_state_type state_ff, state_in;

   // ---------------------------------------------------------------- registers
   logic [CFG_W-1:0]         width_ff, width_in;
   logic [CFG_W-1:0]         height_ff, height_in;
   logic [COUNT_W-1:0]       cur_ff, cur_in;
   logic [COUNT_W-1:0]       max_ff, max_in;
   logic [WA_W-1:0]          clr_addr_ff, clr_addr_in;
   logic                     v1_ff, v1_in;       // span word read in flight
   logic                     v2_ff, v2_in;       // span popcount ready
   logic                     rsp_valid_ff, rsp_valid_in;

   bce_op_type               op_ff;
   logic signed [COORD_W-1:0] cx_ff;
   logic signed [COORD_W-1:0] cy_ff;
   logic                     alpha_nz_ff;
   logic                     hit_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [YW-1:0]            ey_ff;
   logic [XW-1:0]            lx_ff;
   logic [XW-1:0]            rx_ff;
   logic [IDX_W-1:0]         base_ff;
   logic [WA_W-1:0]          wa_ff;
   logic [WA_W-1:0]          wa_end_ff;
   logic [LW-1:0]            lo_bit_ff;
   logic [LW-1:0]            hi_bit_ff;
   logic                     first_ff;
   logic [WORD_BITS-1:0]     mask_ff;
   logic [WA_W-1:0]          wr_addr_ff;
   logic [LW:0]              pop_ff;
   logic                     rsp_hit_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic [COUNT_W-1:0]       rsp_max_ff;

   // ---------------------------------------------------------------- map RAM
   logic [WORD_BITS-1:0] map_mem [WORDS];
   logic [WORD_BITS-1:0] mem_rd_ff;
   logic                 mem_we;
   logic [WA_W-1:0]      mem_wa;
   logic [WA_W-1:0]      mem_ra;
   logic [WORD_BITS-1:0] mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= map_mem[mem_ra];   // read-first: old word on a same-address write
   end

   // ---------------------------------------------------------------- helpers
   function automatic logic [LW:0] word_ones(input logic [WORD_BITS-1:0] w);
      logic [LW:0] total;
      logic [3:0]  part;
      total = '0;
      for (int b = 0; b < WORD_BYTES; b++) begin
         part = '0;
         for (int i = 0; i < 8; i++) begin
            part = part + 4'(w[8*b+i]);
         end
         total = total + (LW+1)'(part);
      end
      return total;
   endfunction

   // ---------------------------------------------------------------- decode
   bce_op_type        req_op;
   logic              req_fire;
   logic [RAD_W-1:0]  r_sat;
   logic [WW-1:0]     wact;
   logic [HW-1:0]     hact;

   assign req_op    = bce_op_type'(req_type);
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // radius saturates at MAX_RADIUS
   always_comb begin
      if (32'(req_radius) > MAX_RADIUS) begin
         r_sat = RAD_W'(MAX_RADIUS);
      end else begin
         r_sat = RAD_W'(req_radius);
      end
   end

   // active size: zero reads as one, oversize reads as the maximum
   always_comb begin
      if (width_ff == '0) begin
         wact = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         wact = WW'(MAX_WIDTH);
      end else begin
         wact = WW'(width_ff);
      end
      if (height_ff == '0) begin
         hact = HW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         hact = HW'(MAX_HEIGHT);
      end else begin
         hact = HW'(height_ff);
      end
   end

   logic signed [SUM_W-1:0] wact_s;
   logic signed [SUM_W-1:0] hact_s;
   logic signed [SUM_W-1:0] cx_s;
   logic signed [SUM_W-1:0] cy_s;
   logic                    pt_inside;

   assign wact_s    = $signed(SUM_W'(wact));
   assign hact_s    = $signed(SUM_W'(hact));
   assign cx_s      = SUM_W'(cx_ff);
   assign cy_s      = SUM_W'(cy_ff);
   assign pt_inside = (cx_s >= 0) && (cx_s < wact_s) && (cy_s >= 0) && (cy_s < hact_s);

   // ---------------------------------------------------------------- circle walker
   bce_walk_cmd_type        walk_cmd;
   bce_walk_stat_type       walk_stat;
   logic signed [RAD_W:0]   row_dy;
   logic [RAD_W-1:0]        half_width;

   bce_circle_walk #(
      .RAD_W (RAD_W)
   ) u_walk (
      .clock      (clock),
      .reset      (reset),
      .walk_cmd   (walk_cmd),
      .radius     (r_sat),
      .walk_stat  (walk_stat),
      .row_dy     (row_dy),
      .half_width (half_width)
   );

   // row span before clipping: [cx-half, cx+half] on row cy+dy
   logic signed [SUM_W-1:0] row_y;
   logic signed [SUM_W-1:0] span_lo;
   logic signed [SUM_W-1:0] span_hi;
   logic                    row_skip;
   logic [XW-1:0]           clip_lx;
   logic [XW-1:0]           clip_rx;

   assign row_y    = cy_s + SUM_W'(row_dy);
   assign span_lo  = cx_s - $signed(SUM_W'(half_width));
   assign span_hi  = cx_s + $signed(SUM_W'(half_width));
   assign row_skip = (row_y < 0) || (row_y >= hact_s) || (span_hi < 0) || (span_lo >= wact_s);
   assign clip_lx  = (span_lo < 0) ? '0 : XW'($unsigned(span_lo));
   assign clip_rx  = (span_hi >= wact_s) ? XW'(wact - WW'(1)) : XW'($unsigned(span_hi));

   // one shared multiplier: pixel row or span row times active width
   logic [IDX_W-1:0] mul_y;
   logic [IDX_W-1:0] mul_prod;
   logic [IDX_W-1:0] span_idx0;
   logic [IDX_W-1:0] span_idx1;

   assign mul_y     = (state_ff == S_PT_IDX) ? IDX_W'($unsigned(cy_ff)) : IDX_W'(ey_ff);
   assign mul_prod  = mul_y * IDX_W'(wact);
   assign span_idx0 = base_ff + IDX_W'(lx_ff);
   assign span_idx1 = base_ff + IDX_W'(rx_ff);

   // word mask: partial at the first and last word of a span
   logic [LW-1:0]        mask_lo;
   logic [LW-1:0]        mask_hi;
   logic [WORD_BITS-1:0] span_mask;
   logic                 span_last;

   assign span_last = (wa_ff == wa_end_ff);
   assign mask_lo   = first_ff ? lo_bit_ff : '0;
   assign mask_hi   = span_last ? hi_bit_ff : '1;
   assign span_mask = ({WORD_BITS{1'b1}} << mask_lo) & ({WORD_BITS{1'b1}} >> (~mask_hi));

   // pixel access
   logic                 bit_old;
   logic [WORD_BITS-1:0] bit_sel;

   assign bit_old = mem_rd_ff[idx_ff[LW-1:0]];
   assign bit_sel = WORD_BITS'(1) << idx_ff[LW-1:0];

   logic clr_last;
   logic done_ok;
   logic done_fire;

   assign clr_last = (clr_addr_ff == WA_W'(WORDS - 1));
   // post only once the erase pipeline has settled the count
   assign done_ok  = (!rsp_valid_ff || rsp_ready) && !v1_ff && !v2_ff;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in  = state_ff;
      walk_cmd  = '0;
      done_fire = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            if (clr_last) state_in = S_IDLE;
         end
         S_CLR: begin
            if (clr_last) state_in = S_DONE;
         end
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  OP_CLEAR:          state_in = S_CLR;
                  OP_LOAD, OP_QUERY: state_in = S_PT_IDX;
                  OP_ERASE: begin
                     if (r_sat != '0) begin
                        walk_cmd.start = 1'b1;
                        state_in       = S_E_ADJ;
                     end else begin
                        state_in = S_DONE;   // zero radius erases nothing
                     end
                  end
               endcase
            end
         end
         S_PT_IDX: state_in = pt_inside ? S_PT_RD : S_DONE;
         S_PT_RD:  state_in = S_PT_WR;
         S_PT_WR:  state_in = S_DONE;
         S_E_ADJ: begin
            if (walk_stat.settled) state_in = row_skip ? S_E_NEXT : S_E_MUL;
         end
         S_E_MUL:  state_in = S_E_IDX;
         S_E_IDX:  state_in = S_E_SPAN;
         S_E_SPAN: begin
            if (span_last) state_in = S_E_NEXT;
         end
         S_E_NEXT: begin
            walk_cmd.advance = 1'b1;
            state_in         = walk_stat.last_row ? S_DONE : S_E_ADJ;
         end
         S_DONE: begin
            if (done_ok) begin
               done_fire = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   // ---------------------------------------------------------------- RAM ports
   // The S_E_NEXT, S_E_ADJ, S_E_MUL and S_E_IDX states lie between the spans of two rows,
   // so a span write-back always lands before the next span reads a word it may share.
   assign mem_ra = (state_ff == S_PT_RD) ? idx_ff[IDX_W-1:LW] : wa_ff;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = clr_addr_ff;
      mem_wd = '0;
      priority if (state_ff == S_INIT || state_ff == S_CLR) begin
         mem_we = 1'b1;
      end else if (v1_ff) begin
         mem_we = 1'b1;
         mem_wa = wr_addr_ff;
         mem_wd = mem_rd_ff & ~mask_ff;
      end else if (state_ff == S_PT_WR && op_ff == OP_LOAD) begin
         mem_we = 1'b1;
         mem_wa = idx_ff[IDX_W-1:LW];
         mem_wd = (mem_rd_ff & ~bit_sel) | (alpha_nz_ff ? bit_sel : '0);
      end
   end

   // ---------------------------------------------------------------- counters
   always_comb begin
      cur_in = cur_ff;
      max_in = max_ff;
      priority if (state_ff == S_CLR) begin
         cur_in = '0;
         max_in = '0;
      end else if (v2_ff) begin
         cur_in = (cur_ff > COUNT_W'(pop_ff)) ? cur_ff - COUNT_W'(pop_ff) : '0;
      end else if (state_ff == S_PT_WR && op_ff == OP_LOAD) begin
         if (!bit_old && alpha_nz_ff) begin
            cur_in = (cur_ff != '1) ? cur_ff + COUNT_W'(1) : cur_ff;
            max_in = (max_ff != '1) ? max_ff + COUNT_W'(1) : max_ff;
         end else if (bit_old && !alpha_nz_ff) begin
            cur_in = (cur_ff != '0) ? cur_ff - COUNT_W'(1) : cur_ff;
            max_in = (max_ff != '0) ? max_ff - COUNT_W'(1) : max_ff;
         end
      end
   end

   // ---------------------------------------------------------------- misc control
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we && csr_index == CSR_WIDTH) width_in = csr_wdata;
      if (csr_we && csr_index == CSR_HEIGHT) height_in = csr_wdata;

      clr_addr_in = clr_addr_ff;
      if (state_ff == S_INIT || state_ff == S_CLR) begin
         clr_addr_in = clr_last ? '0 : clr_addr_ff + WA_W'(1);
      end

      v1_in        = (state_ff == S_E_SPAN);
      v2_in        = v1_ff;
      rsp_valid_in = done_fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         width_ff     <= CFG_DIM_RESET;
         height_ff    <= CFG_DIM_RESET;
         cur_ff       <= '0;
         max_ff       <= '0;
         clr_addr_ff  <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         cur_ff       <= cur_in;
         max_ff       <= max_in;
         clr_addr_ff  <= clr_addr_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff       <= req_op;
         cx_ff       <= req_x_pos;
         cy_ff       <= req_y_pos;
         alpha_nz_ff <= (req_pixel_alpha != '0);
         hit_ff      <= 1'b0;
      end
      if (state_ff == S_PT_IDX) begin
         idx_ff <= mul_prod + IDX_W'($unsigned(cx_ff));
      end
      if (state_ff == S_PT_WR && op_ff == OP_QUERY) begin
         hit_ff <= bit_old;
      end
      if (state_ff == S_E_ADJ && walk_stat.settled) begin
         ey_ff <= YW'($unsigned(row_y));
         lx_ff <= clip_lx;
         rx_ff <= clip_rx;
      end
      if (state_ff == S_E_MUL) begin
         base_ff <= mul_prod;
      end
      if (state_ff == S_E_IDX) begin
         wa_ff     <= span_idx0[IDX_W-1:LW];
         wa_end_ff <= span_idx1[IDX_W-1:LW];
         lo_bit_ff <= span_idx0[LW-1:0];
         hi_bit_ff <= span_idx1[LW-1:0];
         first_ff  <= 1'b1;
      end
      if (state_ff == S_E_SPAN) begin
         mask_ff    <= span_mask;
         wr_addr_ff <= wa_ff;
         wa_ff      <= wa_ff + WA_W'(1);
         first_ff   <= 1'b0;
      end
      if (v1_ff) begin
         pop_ff <= word_ones(mem_rd_ff & mask_ff);   // solid pixels this word loses
      end
      if (done_fire) begin
         rsp_hit_ff   <= hit_ff;
         rsp_count_ff <= cur_ff;
         rsp_max_ff   <= max_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_solid_count = rsp_count_ff;
   assign rsp_solid_max   = rsp_max_ff;

   // ---------------------------------------------------------------- checks
`include "assert_macros.svh"

   `ASSERT_IMPLY(a_count_order, clock, reset, 1'b1, cur_ff <= max_ff, "solid count above loaded count")
   `ASSERT_IMPLY(a_idle_drained, clock, reset, state_ff == S_IDLE, !v1_ff && !v2_ff, "erase pipeline busy in idle")
   `ASSERT_IMPLY(a_pt_no_span, clock, reset, state_ff == S_PT_RD, !v1_ff, "span write-back overlaps pixel read")
   `ASSERT_NEXT(a_done_posts, clock, reset, done_fire, rsp_valid_ff, "finished transaction not posted")

endmodule

[dv/tb_bitmask_circle_erase_core.sv]
// Testbench for bitmask_circle_erase_core: directed and random transactions checked against a bitmap predictor.
`timescale 1ns / 100ps

module tb_bitmask_circle_erase_core;
   import bce_pkg::*;

   localparam int MAP_PX      = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
   localparam int COUNT_CAP   = (1 << COUNT_W) - 1;
   localparam int RADIUS_TOP  = (1 << RAD_IN_W) - 1;
   localparam int MAX_GAP     = 18;
   // Covers the reset sweep, each clear and an r=63 erase, none of which accepts a request.
   localparam int STALL_LIMIT = 20000;
   localparam int TAIL_CYCLES = 50;

   // One request transaction plus the idle gap the sender inserts ahead of it.
   typedef struct {
      bce_op_type                op;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [RAD_IN_W-1:0]       radius;
      logic [ALPHA_W-1:0]        alpha;
      int                        gap;
   } px_request_type;

   typedef struct packed {
      logic               hit;
      logic [COUNT_W-1:0] solid_count;
      logic [COUNT_W-1:0] solid_max;
   } px_answer_type;

   // Shadow bitmap with both pixel counters; predicts one answer per request.
   class solidity_scoreboard;
      bit            shadow_map [MAP_PX];
      int            live_px;
      int            loaded_px;
      int            cfg_width;
      int            cfg_height;
      px_answer_type pending_answers [$];
      int            op_seen [4];
      int            answers_checked;
      int            hits_seen;
      int            peak_live;
      int            mismatches;

      function new();
         cfg_width  = CFG_DIM_RESET;
         cfg_height = CFG_DIM_RESET;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
         if (idx == CSR_WIDTH) cfg_width = value;
         else cfg_height = value;
      endfunction

      // Zero reads as 1, anything past the map reads as the map size.
      function int act_width();
         if (cfg_width < 1) return 1;
         return (cfg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg_width;
      endfunction

      function int act_height();
         if (cfg_height < 1) return 1;
         return (cfg_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cfg_height;
      endfunction

      function int outstanding();
         return pending_answers.size();
      endfunction

      // Filled disc, row by row; each span is clipped to the active area.
      function void wipe_disc(int cx, int cy, int r, int w, int h);
         int yy, xm, lx, rx, idx;
         for (int dy = -r; dy <= r; dy++) begin
            yy = cy + dy;
            if (yy < 0 || yy >= h) continue;
            xm = 0;
            for (int xx = -r; xx <= r; xx++) begin
               if (xx * xx + dy * dy <= r * r) begin
                  xm = xx;
                  break;
               end
            end
            lx = cx + xm;
            rx = cx - xm;
            if (rx < 0 || lx >= w) continue;
            if (rx >= w) rx = w - 1;
            if (lx < 0) lx = 0;
            for (int xx = lx; xx <= rx; xx++) begin
               idx = yy * w + xx;
               if (shadow_map[idx]) begin
                  shadow_map[idx] = 1'b0;
                  if (live_px > 0) live_px--;
               end
            end
         end
      endfunction

      function void apply_request(px_request_type t);
         int            w, h, px, py, r, idx;
         bit            on_map, solid_now;
         px_answer_type ans;
         w      = act_width();
         h      = act_height();
         px     = t.x;
         py     = t.y;
         r      = t.radius;
         on_map = px >= 0 && px < w && py >= 0 && py < h;
         idx    = py * w + px;
         ans    = '0;
         op_seen[t.op]++;
         case (t.op)
            OP_CLEAR: begin
               foreach (shadow_map[i]) shadow_map[i] = 1'b0;
               live_px   = 0;
               loaded_px = 0;
            end
            OP_LOAD: begin
               if (on_map) begin
                  solid_now = t.alpha != '0;
                  if (!shadow_map[idx] && solid_now) begin
                     if (live_px < COUNT_CAP) live_px++;
                     if (loaded_px < COUNT_CAP) loaded_px++;
                  end else if (shadow_map[idx] && !solid_now) begin
                     if (live_px > 0) live_px--;
                     if (loaded_px > 0) loaded_px--;
                  end
                  shadow_map[idx] = solid_now;
               end
            end
            OP_ERASE: begin
               if (r > DEF_MAX_RADIUS) r = DEF_MAX_RADIUS;
               if (r >= 1) wipe_disc(px, py, r, w, h);
            end
            default: begin
               if (on_map) ans.hit = shadow_map[idx];
            end
         endcase
         if (live_px > peak_live) peak_live = live_px;
         ans.solid_count = COUNT_W'(live_px);
         ans.solid_max   = COUNT_W'(loaded_px);
         pending_answers = {pending_answers, ans};
      endfunction

      function void check_response(logic hit, logic [COUNT_W-1:0] cnt,
                                   logic [COUNT_W-1:0] mx);
         px_answer_type exp_ans;
         if (pending_answers.size() == 0) begin
            $error("response with nothing outstanding: hit %0d solid_count %0d solid_max %0d",
                   hit, cnt, mx);
            mismatches++;
            return;
         end
         exp_ans = pending_answers.pop_front();
         answers_checked++;
         if (hit === 1'b1) hits_seen++;
         if (hit !== exp_ans.hit) begin
            $error("hit: expected %0d, actual %0d", exp_ans.hit, hit);
            mismatches++;
         end
         if (cnt !== exp_ans.solid_count) begin
            $error("solid_count: expected %0d, actual %0d", exp_ans.solid_count, cnt);
            mismatches++;
         end
         if (mx !== exp_ans.solid_max) begin
            $error("solid_max: expected %0d, actual %0d", exp_ans.solid_max, mx);
            mismatches++;
         end
      endfunction
   endclass

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      req_valid       = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_type        = OP_CLEAR;
   logic signed [COORD_W-1:0] req_x_pos       = '0;
   logic signed [COORD_W-1:0] req_y_pos       = '0;
   logic [RAD_IN_W-1:0]       req_radius      = '0;
   logic [ALPHA_W-1:0]        req_pixel_alpha = '0;
   logic                      rsp_valid;
   logic                      rsp_ready       = 1'b0;
   logic                      rsp_hit;
   logic [COUNT_W-1:0]        rsp_solid_count;
   logic [COUNT_W-1:0]        rsp_solid_max;
   logic                      csr_we          = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index       = CSR_WIDTH;
   logic [CFG_W-1:0]          csr_wdata       = '0;

   bit                 steady      = 1'b0;  // no idling on either side while set
   int                 idle_cycles = 0;
   int                 area_count  = 1;     // reset size counts as the first
   solidity_scoreboard board;
   px_request_type     batch [$];           // transactions queued for the sender

   bitmask_circle_erase_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_x_pos       (req_x_pos),
      .req_y_pos       (req_y_pos),
      .req_radius      (req_radius),
      .req_pixel_alpha (req_pixel_alpha),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_solid_count (rsp_solid_count),
      .rsp_solid_max   (rsp_solid_max),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Watchdog: any cycle with a transaction on either channel restarts the count.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   // Response side: random stall per result, then hold ready until one is taken.
   // Signals are sampled right after the edge, so they are the values the edge saw.
   initial begin : rsp_side
      int stall;
      forever begin
         stall = steady ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         board.check_response(rsp_hit, rsp_solid_count, rsp_solid_max);
      end
   end

   function automatic void add_item(bce_op_type op, int x, int y, int r, int a);
      px_request_type t;
      t.op     = op;
      t.x      = COORD_W'(x);
      t.y      = COORD_W'(y);
      t.radius = RAD_IN_W'(r);
      t.alpha  = ALPHA_W'(a);
      t.gap    = steady ? 0 : $urandom_range(0, MAX_GAP);
      batch    = {batch, t};
   endfunction

   // Mostly a window of up to 40 pixels per axis and 3 pixels past each of its edges, sometimes anywhere.
   function automatic int pick_coord(int org, int ext);
      logic signed [COORD_W-1:0] wild;
      if ($urandom_range(0, 9) == 0) begin
         wild = COORD_W'($urandom);
         return wild;
      end
      return org + int'($urandom_range(0, ext + 5)) - 3;
   endfunction

   // Small discs keep erase time down; a few mid-size and full-size ones.
   function automatic int pick_radius();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return RADIUS_TOP;
      if (roll < 4) return $urandom_range(7, 24);
      return $urandom_range(0, 6);
   endfunction

   // Sender: valid stays up across back-to-back transactions and drops only after the
   // last one or when the next one has a gap, so valid sees one assignment per edge.
   task automatic run_batch();
      for (int i = 0; i < batch.size(); i++) begin
         if (batch[i].gap > 0) repeat (batch[i].gap) @(posedge clock);
         req_valid       <= 1'b1;
         req_type        <= batch[i].op;
         req_x_pos       <= batch[i].x;
         req_y_pos       <= batch[i].y;
         req_radius      <= batch[i].radius;
         req_pixel_alpha <= batch[i].alpha;
         @(posedge clock);
         while (req_ready !== 1'b1) @(posedge clock);
         board.apply_request(batch[i]);
         if (i == batch.size() - 1 || batch[i + 1].gap > 0) req_valid <= 1'b0;
      end
      batch.delete();
   endtask

   task automatic wait_drained();
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   // Size registers are only touched with the block idle; the predictor
   // follows after each write edge.
   task automatic set_area(int w_val, int h_val);
      wait_drained();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= CFG_W'(w_val);
      @(posedge clock);
      board.write_reg(CSR_WIDTH, CFG_W'(w_val));
      csr_index <= CSR_HEIGHT;
      csr_wdata <= CFG_W'(h_val);
      @(posedge clock);
      board.write_reg(CSR_HEIGHT, CFG_W'(h_val));
      csr_we <= 1'b0;
      area_count++;
   endtask

   // One size setting: loads dominate so erases and queries find solid pixels;
   // clears are rare since each sweeps the whole RAM.
   task automatic random_phase(int w_val, int h_val, int n, bit no_idle, bit hold_mid);
      int w, h, ext_x, ext_y, org_x, org_y, pick;
      set_area(w_val, h_val);
      steady = no_idle;
      w      = board.act_width();
      h      = board.act_height();
      ext_x  = (w < 40) ? w : 40;
      ext_y  = (h < 40) ? h : 40;
      org_x  = $urandom_range(0, w - ext_x);
      org_y  = $urandom_range(0, h - ext_y);
      for (int i = 0; i < n; i++) begin
         // Sender holds off until every answer is back, then resumes.
         if (hold_mid && i == n / 2) begin
            run_batch();
            wait_drained();
         end
         pick = $urandom_range(0, 99);
         if (pick < 5)
            add_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
         else if (pick < 50)
            add_item(OP_LOAD, pick_coord(org_x, ext_x), pick_coord(org_y, ext_y),
                     $urandom, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255));
         else if (pick < 70)
            add_item(OP_ERASE, pick_coord(org_x, ext_x), pick_coord(org_y, ext_y),
                     pick_radius(), $urandom);
         else
            add_item(OP_QUERY, pick_coord(org_x, ext_x), pick_coord(org_y, ext_y),
                     $urandom, $urandom);
      end
      run_batch();
   endtask

   initial begin : stimulus
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed pass at the reset size (512 x 512).
      add_item(OP_QUERY, 0, 0, 0, 0);              // empty map
      add_item(OP_LOAD, 0, 0, 0, 255);
      add_item(OP_LOAD, 511, 511, 0, 1);           // far corner
      add_item(OP_LOAD, 512, 0, 0, 7);             // one past the right edge: ignored
      add_item(OP_LOAD, -1, 5, 0, 9);              // negative column: ignored
      add_item(OP_LOAD, 1023, -1024, 0, 128);      // coordinate extremes: ignored
      add_item(OP_QUERY, 0, 0, 0, 0);
      add_item(OP_QUERY, 511, 511, 0, 0);
      add_item(OP_QUERY, -1024, 1023, 63, 255);    // off map reads 0
      add_item(OP_LOAD, 0, 0, 0, 0);               // solid to clear lowers both counts
      add_item(OP_LOAD, 0, 0, 0, 0);               // already clear: no change
      add_item(OP_LOAD, 10, 10, 0, 8'h80);
      add_item(OP_LOAD, 10, 11, 0, 8'h01);
      add_item(OP_ERASE, 10, 10, 0, 0);            // zero radius does nothing
      add_item(OP_ERASE, 10, 10, 1, 0);
      add_item(OP_ERASE, 511, 511, 63, 0);         // clipped at the corner
      add_item(OP_ERASE, -1024, -1024, 63, 0);     // entirely off the map
      add_item(OP_LOAD, 256, 256, 0, 8'hAA);
      add_item(OP_LOAD, 300, 300, 0, 8'h55);       // just inside r=63
      add_item(OP_LOAD, 301, 301, 0, 8'h0F);       // just outside r=63
      add_item(OP_ERASE, 256, 256, 63, 0);         // full disc mid map
      add_item(OP_QUERY, 300, 300, 0, 0);
      add_item(OP_CLEAR, 0, 0, 0, 0);
      add_item(OP_QUERY, 301, 301, 0, 0);
      run_batch();

      // Size sweep: zero (reads as 1), small, past the map, single column,
      // single row, another small one and exactly full.
      random_phase(0, 0, 10, 1'b0, 1'b0);
      random_phase(17, 9, 36, 1'b0, 1'b1);
      random_phase(1023, 1023, 20, 1'b1, 1'b0);
      random_phase(1, 512, 16, 1'b0, 1'b0);
      random_phase(512, 1, 16, 1'b0, 1'b0);
      random_phase(24, 20, 20, 1'b1, 1'b0);
      random_phase(512, 512, 12, 1'b0, 1'b0);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.outstanding() != 0) begin
         $error("%0d responses never arrived", board.outstanding());
         board.mismatches++;
      end

      $display("covered %0d transactions (%0d clear, %0d load, %0d erase, %0d query), %0d sizes",
               board.op_seen[0] + board.op_seen[1] + board.op_seen[2] + board.op_seen[3],
               board.op_seen[OP_CLEAR], board.op_seen[OP_LOAD], board.op_seen[OP_ERASE],
               board.op_seen[OP_QUERY], area_count);
      $display("checked %0d responses, %0d hits, peak solid count %0d",
               board.answers_checked, board.hits_seen, board.peak_live);
      if (board.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
